FILE: hdl/sha256_pkg.sv
// Package for the SHA-256 message hasher: constants, types and round functions.
package sha256_pkg;

	localparam int unsigned QueueDepth = 4;

	// Front-to-back queue entry: one classified byte transfer
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} core_state_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

FILE: hdl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
// One byte transfer per cycle enters a four-entry queue while it is not full; while idle, the
// engine takes one byte per cycle and, on each 64th byte, runs 64 rounds and then a fold step,
// taking no bytes meanwhile. The end mark costs one or two blocks (two when 56 or more bytes
// sit in the tail, or when the end byte completes a block) and the digest appears, after the
// last block is folded, on one output transfer. A new end mark waits while a digest is not
// yet taken.
module sha256_message_hasher #(
	parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word_0,
	output logic [31:0] digest_word_1,
	output logic [31:0] digest_word_2,
	output logic [31:0] digest_word_3,
	output logic [31:0] digest_word_4,
	output logic [31:0] digest_word_5,
	output logic [31:0] digest_word_6,
	output logic [31:0] digest_word_7
);
	import sha256_pkg::*;

	sha_item_t   in_item, q_item;
	logic        full, empty, pop, keep;
	logic [31:0] dig [8];

	// Front end: drop items that carry neither a byte nor an end mark
	assign in_item  = '{data: message_byte, present: byte_present, last: end_of_message};
	assign keep     = byte_present || end_of_message;
	assign in_stall = full;

	sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk, .arst_n,
		.push(in_valid && keep), .push_data(in_item), .full,
		.pop, .pop_data(q_item), .empty
	);

	sha256_core u_core (
		.clk, .arst_n,
		.item_valid(!empty), .item(q_item), .item_pop(pop),
		.out_valid, .out_stall, .digest(dig)
	);

	assign digest_word_0 = dig[0];
	assign digest_word_1 = dig[1];
	assign digest_word_2 = dig[2];
	assign digest_word_3 = dig[3];
	assign digest_word_4 = dig[4];
	assign digest_word_5 = dig[5];
	assign digest_word_6 = dig[6];
	assign digest_word_7 = dig[7];

endmodule

FILE: hdl/sha256_fifo.sv
// Small queue between the byte front end and the compression engine.
module sha256_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sha256_pkg::sha_item_t push_data,
	output logic                  full,
	input  logic                  pop,
	output sha256_pkg::sha_item_t pop_data,
	output logic                  empty
);
	import sha256_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha_item_t        mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

endmodule

FILE: hdl/sha256_core.sv
// Back end: block assembly, padding, 64-round compression and digest output.
module sha256_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  sha256_pkg::sha_item_t item,
	output logic                  item_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           digest [8]
);
	import sha256_pkg::*;

	core_state_t state_q, state_d;
	logic [31:0] w_q [16];          // message schedule window, also block buffer
	logic [31:0] v_q [8];           // working variables a..h
	logic [31:0] h_q [8];           // chaining value
	logic [5:0]  pos_q;             // bytes in block
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        final_q;           // compressing the last block
	logic        tail_q;            // padding still owes a length block
	logic        mark_q;            // pad mark already sent, next pad block is zeros + length
	logic [31:0] dig_q [8];
	logic        out_valid_q;

	logic [31:0] t1, t2, w_new;
	logic        consume, start_blk, start_pad;
	logic [31:0] word_ins;
	logic [31:0] pad_w [16];

	assign out_valid = out_valid_q;
	assign digest    = dig_q;

	// Round datapath
	always_comb begin
		t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + w_q[0];
		t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
	end

	// Control: consume queue items only when idle
	always_comb begin
		state_d   = state_q;
		item_pop  = 1'b0;
		consume   = 1'b0;
		start_blk = 1'b0;
		start_pad = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && !(item.last && out_valid_q)) begin
					item_pop = 1'b1;
					consume  = 1'b1;
					if (item.present && pos_q == 6'd63) begin
						start_blk = 1'b1;
						state_d   = ST_ROUND;
					end else if (item.last) begin
						start_pad = 1'b1;
						state_d   = ST_PAD;
					end
				end
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (final_q) state_d = ST_EMIT;
				else if (tail_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: state_d = ST_ROUND;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Byte placed into its word of the buffer
	always_comb begin
		word_ins = w_q[pos_q[5:2]];
		case (pos_q[1:0])
			2'd0: word_ins[31:24] = item.data;
			2'd1: word_ins[23:16] = item.data;
			2'd2: word_ins[15:8]  = item.data;
			default: word_ins[7:0] = item.data;
		endcase
	end

	// Tail with the pad mark at pos_q and zeros after it
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pad_w[i] = w_q[i];
			for (int b = 0; b < 4; b++) begin
				if (6'(4*i + b) > pos_q) pad_w[i][31-8*b -: 8] = 8'h00;
				else if (6'(4*i + b) == pos_q) pad_w[i][31-8*b -: 8] = PAD_BYTE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= H_INIT;
			pos_q       <= '0;
			bits_q      <= '0;
			rnd_q       <= '0;
			final_q     <= 1'b0;
			tail_q      <= 1'b0;
			mark_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (consume && item.present) begin
						w_q[pos_q[5:2]] <= word_ins;
						pos_q  <= pos_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					if (start_blk) begin
						v_q     <= h_q;
						rnd_q   <= '0;
						final_q <= 1'b0;
						tail_q  <= item.last;
					end
					if (start_pad) tail_q <= 1'b1;
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					rnd_q   <= rnd_q + 6'd1;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (final_q) begin
						for (int i = 0; i < 8; i++) dig_q[i] <= h_q[i] + v_q[i];
					end
				end
				ST_PAD: begin
					if (mark_q) begin
						// Extra block of an overflow pad: zeros, then the bit count
						for (int i = 0; i < 14; i++) w_q[i] <= '0;
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						final_q <= 1'b1;
						tail_q  <= 1'b0;
						mark_q  <= 1'b0;
					end else if (pos_q < 6'd56) begin
						// Tail, pad mark and bit count fit in one block
						for (int i = 0; i < 14; i++) w_q[i] <= pad_w[i];
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
						final_q <= 1'b1;
						tail_q  <= 1'b0;
					end else begin
						// No room for the bit count: it goes into one more block
						for (int i = 0; i < 16; i++) w_q[i] <= pad_w[i];
						final_q <= 1'b0;
						tail_q  <= 1'b1;
						mark_q  <= 1'b1;
					end
					pos_q <= '0;
					v_q   <= h_q;
					rnd_q <= '0;
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					h_q    <= H_INIT;
					bits_q <= '0;
					pos_q  <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule
